// ===== rtl/sqs_pkg.sv =====
// Shared constants, widths and the quantile level table for the sample
// quantile snapshot block. No dependencies.
package sqs_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_SAMPLES = 1024;
  localparam int AW   = $clog2(MAX_SAMPLES);      // store address width
  localparam int CW   = $clog2(MAX_SAMPLES + 1);  // sample count width
  localparam int SUMW = SAMPLE_BITS + CW;         // running sum width
  localparam int DW   = SUMW + 16;                // mean dividend width
  localparam int DCW  = $clog2(DW + 1);
  localparam int QW   = 48;                       // Q32.16 result width
  localparam int FW   = 20;                       // level fraction bits
  localparam int LW   = 21;                       // level width
  localparam int PW   = LW + CW;                  // position width
  localparam int NQ   = 7;                        // quantiles per result
  localparam int PRW  = FW + SAMPLE_BITS;         // interpolation product
  localparam int CFG_AW = 3;

  localparam logic [LW-1:0] Q_ONE = LW'(1 << FW);
  localparam logic [CFG_AW-1:0] ADDR_CUSTOM_Q = '0;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_CAND  = 8'b0000_0100,
    ST_CLAT  = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_QUANT = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  // Quantile level in Q1.20; slot 6 is the configured one, saturated at 1.0
  function automatic logic [LW-1:0] level_sel(logic [2:0] k, logic [LW-1:0] custom);
    logic [LW-1:0] lv;
    unique case (k)
      3'd0:    lv = LW'(524288);
      3'd1:    lv = LW'(786432);
      3'd2:    lv = LW'(943718);
      3'd3:    lv = LW'(996147);
      3'd4:    lv = LW'(1038090);
      3'd5:    lv = LW'(1047527);
      default: lv = (custom > Q_ONE) ? Q_ONE : custom;
    endcase
    return lv;
  endfunction

endpackage

// ===== rtl/sqs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sample_quantile_snapshot_core.sv =====
// Sample quantile snapshot: top level. Uses sqs_pkg and sqs_ram.
// Samples: one transaction per cycle while idle, written to the sample RAM in arrival order.
// A last transaction with stored samples keeps the block busy through
// 7 rank setups (an empty set goes straight to the result), then every
// sample is taken as a rank candidate and the whole store is scanned through the
// single RAM read port, a bit-serial mean division (59 steps), 7 interpolations.
// Synchronous active-low reset clears count, flags and handshakes and sets the configured level to 0.5.
module sample_quantile_snapshot_core (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] sample
  input  logic [0:0]   in_tuser,   // [0] has_sample
  input  logic         in_tlast,   // last
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [10:0] sample_count, [42:11] min_value, [74:43] max_value,
  // [122:75] mean_value, [170:123] median_value, [218:171] p75_value,
  // [266:219] p90_value, [314:267] p95_value, [362:315] p99_value,
  // [410:363] p999_value, [458:411] custom_value, [463:459] zero
  output logic [463:0] out_tdata,
  output logic [0:0]   out_tuser,  // [0] overflow
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sqs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import sqs_pkg::*;

  localparam int SB = SAMPLE_BITS;

  state_t state_r, state_nxt;

  logic [CW-1:0]   count_r, count_nxt;
  logic            loading_r, loading_nxt;
  logic            dropped_r, dropped_nxt;
  logic [LW-1:0]   custom_r;
  logic            out_valid_r;
  logic            empty_r;

  logic [2:0]      qi_r;
  logic            phase_r;
  logic [AW-1:0]   rlo_r [NQ];
  logic [AW-1:0]   rhi_r [NQ];
  logic [FW-1:0]   frac_r [NQ];
  logic [SB-1:0]   vlo_r [NQ];
  logic [SB-1:0]   vhi_r [NQ];
  logic [SB-1:0]   vmin_r, vmax_r;
  logic [QW-1:0]   res_r [NQ];
  logic [QW-1:0]   mean_r;

  logic [CW-1:0]   j_r;
  logic [CW-1:0]   ia_r;
  logic            pv_r, plast_r;
  logic [SB-1:0]   cand_r;
  logic [CW-1:0]   lt_r, le_r;
  logic [SUMW-1:0] sum_r;

  logic [DW-1:0]   dvd_r;
  logic [CW-1:0]   rem_r;
  logic [DCW-1:0]  div_cnt_r;
  logic [PRW-1:0]  prod_r;
  logic [SB-1:0]   base_r;
  logic [463:0]    out_data_r;
  logic            out_ovf_r;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SB-1:0]   ram_rdata;

  logic            in_acc, cfg_wr;
  logic [CW-1:0]   eff_cnt;

  sqs_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[SB-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == ADDR_CUSTOM_Q) ? 32'(custom_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      custom_r <= LW'(524288);
    end else if (cfg_wr && cfg_paddr == ADDR_CUSTOM_Q) begin
      custom_r <= cfg_pwdata[LW-1:0];
    end
  end

  // Input side: load samples while idle
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign eff_cnt   = loading_r ? count_r : '0;
  assign ram_we    = in_acc && in_tuser[0] && (eff_cnt < CW'(MAX_SAMPLES));
  assign ram_waddr = eff_cnt[AW-1:0];
  assign ram_raddr = (state_r == ST_CAND) ? j_r[AW-1:0] : ia_r[AW-1:0];

  always_comb begin
    count_nxt   = count_r;
    loading_nxt = loading_r;
    dropped_nxt = dropped_r;
    if (in_acc) begin
      if (in_tuser[0]) begin
        loading_nxt = 1'b1;
        if (!loading_r) begin
          dropped_nxt = 1'b0;
          count_nxt   = '0;
        end
        if (ram_we) begin
          count_nxt = eff_cnt + 1'b1;
        end else begin
          dropped_nxt = 1'b1;
        end
      end
      if (in_tlast) begin
        loading_nxt = 1'b0;
      end
    end
  end

  // Rank position for the quantile being prepared
  logic [LW-1:0] lvl;
  logic [PW-1:0] pos;
  logic [PW-FW-1:0] ipos;
  assign lvl  = level_sel(qi_r, custom_r);
  assign pos  = PW'(lvl) * PW'(count_r + 1'b1);
  assign ipos = pos[PW-1:FW];

  // Rank counting of the current candidate
  logic [CW-1:0]   lt_f, le_f;
  logic [SUMW-1:0] sum_c;
  assign lt_f  = lt_r + CW'(ram_rdata < cand_r);
  assign le_f  = le_r + CW'(ram_rdata <= cand_r);
  assign sum_c = sum_r + ((j_r == '0) ? SUMW'(ram_rdata) : '0);

  // Divider step
  logic [CW:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign div_ge = rem_sh >= {1'b0, count_r};

  // Control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_tlast) begin
                  state_nxt = (count_nxt == '0) ? ST_FIN : ST_PREP;
                end
      ST_PREP:  if (qi_r == 3'(NQ - 1)) state_nxt = ST_CAND;
      ST_CAND:  state_nxt = ST_CLAT;
      ST_CLAT:  state_nxt = ST_SCAN;
      ST_SCAN:  if (pv_r && plast_r) begin
                  state_nxt = (j_r == count_r - 1'b1) ? ST_DIV : ST_CAND;
                end
      ST_DIV:   if (div_cnt_r == '0) state_nxt = ST_QUANT;
      ST_QUANT: if (phase_r && qi_r == 3'(NQ - 1)) state_nxt = ST_FIN;
      ST_FIN:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      loading_r   <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      plast_r     <= 1'b0;
      qi_r        <= '0;
      phase_r     <= 1'b0;
      empty_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      loading_r <= loading_nxt;
      dropped_r <= dropped_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && in_acc && in_tlast) begin
        empty_r <= (count_nxt == '0);
        qi_r    <= '0;
        phase_r <= 1'b0;
      end
      if (state_r == ST_PREP) begin
        qi_r <= (qi_r == 3'(NQ - 1)) ? '0 : qi_r + 1'b1;
      end
      if (state_r == ST_QUANT) begin
        phase_r <= ~phase_r;
        if (phase_r) qi_r <= qi_r + 1'b1;
      end
      // scan issue pipeline
      if (state_r == ST_SCAN && ia_r < count_r) begin
        pv_r    <= 1'b1;
        plast_r <= (ia_r == count_r - 1'b1);
      end else begin
        pv_r    <= 1'b0;
        plast_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // rank targets, shifted in from the top
    if (state_r == ST_PREP) begin
      for (int k = 0; k < NQ - 1; k++) begin
        rlo_r[k]  <= rlo_r[k+1];
        rhi_r[k]  <= rhi_r[k+1];
        frac_r[k] <= frac_r[k+1];
      end
      if (ipos == '0) begin
        rlo_r[NQ-1]  <= '0;
        rhi_r[NQ-1]  <= '0;
        frac_r[NQ-1] <= '0;
      end else if (ipos >= (PW-FW)'(count_r)) begin
        rlo_r[NQ-1]  <= AW'(count_r - 1'b1);
        rhi_r[NQ-1]  <= AW'(count_r - 1'b1);
        frac_r[NQ-1] <= '0;
      end else begin
        rlo_r[NQ-1]  <= AW'(ipos - 1'b1);
        rhi_r[NQ-1]  <= AW'(ipos);
        frac_r[NQ-1] <= pos[FW-1:0];
      end
    end

    if (state_r == ST_IDLE) begin
      j_r   <= '0;
      sum_r <= '0;
    end

    if (state_r == ST_CLAT) begin
      cand_r <= ram_rdata;
      ia_r   <= '0;
      lt_r   <= '0;
      le_r   <= '0;
    end

    if (state_r == ST_SCAN) begin
      if (ia_r < count_r) ia_r <= ia_r + 1'b1;
      if (pv_r) begin
        lt_r  <= lt_f;
        le_r  <= le_f;
        sum_r <= sum_c;
        if (plast_r) begin
          // candidate holds every rank in [lt, le)
          for (int k = 0; k < NQ; k++) begin
            if (lt_f <= CW'(rlo_r[k]) && CW'(rlo_r[k]) < le_f) vlo_r[k] <= cand_r;
            if (lt_f <= CW'(rhi_r[k]) && CW'(rhi_r[k]) < le_f) vhi_r[k] <= cand_r;
          end
          if (lt_f == '0) vmin_r <= cand_r;
          if (lt_f <= count_r - 1'b1 && count_r - 1'b1 < le_f) vmax_r <= cand_r;
          j_r       <= j_r + 1'b1;
          dvd_r     <= {sum_c, 16'd0};
          rem_r     <= '0;
          div_cnt_r <= DCW'(DW - 1);
        end
      end
    end

    // restoring division, one quotient bit per cycle
    if (state_r == ST_DIV) begin
      rem_r     <= div_ge ? CW'(rem_sh - {1'b0, count_r}) : CW'(rem_sh);
      dvd_r     <= {dvd_r[DW-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (state_r == ST_QUANT && !phase_r && qi_r == '0) begin
      mean_r <= dvd_r[QW-1:0];
    end

    // interpolation: multiply, then add and rotate
    if (state_r == ST_QUANT) begin
      if (!phase_r) begin
        prod_r <= PRW'(frac_r[0]) * PRW'(vhi_r[0] - vlo_r[0]);
        base_r <= vlo_r[0];
      end else begin
        for (int k = 0; k < NQ - 1; k++) begin
          vlo_r[k]  <= vlo_r[k+1];
          vhi_r[k]  <= vhi_r[k+1];
          frac_r[k] <= frac_r[k+1];
          res_r[k]  <= res_r[k+1];
        end
        res_r[NQ-1] <= {base_r, 16'd0} + QW'(prod_r[PRW-1:4]);
      end
    end

    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_ovf_r <= dropped_r;
      if (empty_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {5'd0, res_r[6], res_r[5], res_r[4], res_r[3], res_r[2],
                       res_r[1], res_r[0], mean_r, vmax_r, vmin_r, count_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

  // Checks
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE)
    else $error("sample RAM written outside idle");
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (lt_r <= le_r && ia_r <= count_r))
    else $error("rank counters inconsistent");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_cnt_r == '0) |=> state_r == ST_QUANT)
    else $error("divider did not hand over");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_tready && count_r != '0)
    else $error("input open or empty store during scan");

endmodule

// ===== bench/sample_quantile_snapshot_core_tb.sv =====
// Testbench for sample_quantile_snapshot_core: directed table plus random sample sets,
// results checked against an in-bench order statistics predictor. Depends on sqs_pkg.
module sample_quantile_snapshot_core_tb;
  import sqs_pkg::*;

  localparam int  CLK_HALF    = 10;
  localparam int  CYCLE_LIMIT = 20000000;
  localparam int  RAND_ITEMS  = 100;   // per idling phase
  localparam int  NUM_ROWS    = 18;

  typedef struct packed {
    logic [10:0] cnt;
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [47:0] mean_v;
    logic [6:0][47:0] qv;   // median, p75, p90, p95, p99, p999, custom
    logic        ovf;
  } snapshot_t;

  typedef struct {
    logic [31:0] smp;
    logic        has;
    logic        lst;
    logic        typed;
    logic [10:0] cnt;
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [47:0] mean_v;
    logic [47:0] q_all;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tlast = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [463:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sample_quantile_snapshot_core dut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predictor state
  logic [31:0] sorted_store[$];
  logic        loading_set;
  logic        dropped;
  logic [20:0] custom_level;
  snapshot_t   pending_snapshots[$];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  stim_row_t dir_rows[NUM_ROWS] = '{
    // empty set right after reset
    '{32'h0, 1'b0, 1'b1, 1'b1, 11'd0, 32'h0, 32'h0, 48'h0, 48'h0},
    '{32'h0, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    // single largest sample, last on the same transaction
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000},
    // empty last keeps the previous set
    '{32'h1234_5678, 1'b0, 1'b1, 1'b1, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000},
    '{32'h0, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{32'h0, 1'b1, 1'b1, 1'b1, 11'd1, 32'h0, 32'h0, 48'h0, 48'h0},
    // data on an idle transaction is ignored
    '{32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'd7, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'd3, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'd9, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'd3, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'd1, 1'b1, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{32'h5A5A_5A5A, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{32'h8000_0000, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{32'hFFFF_FFFE, 1'b1, 1'b1, 1'b0, '0, '0, '0, '0, '0}
  };

  // interpolated quantile at level lv, Q32.16
  function automatic logic [47:0] quantile_of(logic [20:0] lv);
    longint unsigned n, pos, ip, frac, lo, hi;
    n = sorted_store.size();
    if (n == 0) return '0;
    if (lv > Q_ONE) lv = Q_ONE;
    pos = longint'(lv) * (n + 1);
    ip = pos >> FW;
    frac = pos & ((1 << FW) - 1);
    if (ip < 1) return {sorted_store[0], 16'h0};
    if (pos >= (n << FW)) return {sorted_store[n-1], 16'h0};
    lo = sorted_store[ip-1];
    hi = sorted_store[ip];
    return 48'((lo << 16) + ((frac * (hi - lo)) >> 4));
  endfunction

  // update sample set; returns 1 with the snapshot when last closes the set
  function automatic bit absorb_item(logic [31:0] smp, logic has, logic lst,
                                     output snapshot_t snap);
    int pos;
    longint unsigned n, sum, qt, rm;
    logic [20:0] levels[7];
    levels = '{21'd524288, 21'd786432, 21'd943718, 21'd996147, 21'd1038090,
               21'd1047527, custom_level};
    snap = '0;
    if (has) begin
      if (!loading_set) begin
        sorted_store.delete();
        dropped = 1'b0;
        loading_set = 1'b1;
      end
      if (sorted_store.size() < MAX_SAMPLES) begin
        pos = 0;
        while (pos < sorted_store.size() && sorted_store[pos] <= smp) pos++;
        sorted_store.insert(pos, smp);
      end else begin
        dropped = 1'b1;
      end
    end
    if (!lst) return 0;
    loading_set = 1'b0;
    n = sorted_store.size();
    snap.cnt = 11'(n);
    snap.ovf = dropped;
    if (n > 0) begin
      sum = 0;
      foreach (sorted_store[k]) sum += sorted_store[k];
      qt = sum / n;
      rm = sum % n;
      snap.min_v = sorted_store[0];
      snap.max_v = sorted_store[n-1];
      snap.mean_v = 48'((qt << 16) + ((rm << 16) / n));
      for (int k = 0; k < 7; k++) snap.qv[k] = quantile_of(levels[k]);
    end
    return 1;
  endfunction

  // one input transaction; typed_snap replaces the prediction when use_typed
  task automatic send_item(logic [31:0] smp, logic has, logic lst,
                           bit use_typed, snapshot_t typed_snap);
    snapshot_t snap;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= has;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (absorb_item(smp, has, lst, snap))
      pending_snapshots.push_back(use_typed ? typed_snap : snap);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_level(logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CUSTOM_Q; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    custom_level = val[20:0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFF0 | $urandom_range(15);
      2: return 32'h8000_0000 ^ $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // random sets, mostly small, with idle and empty-last noise
  task automatic random_sets(int budget);
    int done, sz;
    snapshot_t unused;
    unused = '0;
    done = 0;
    while (done < budget) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      for (int k = 0; k < sz; k++) begin
        if ($urandom_range(9) == 0) send_item($urandom, 1'b0, 1'b0, 0, unused);
        send_item(rand_sample(), 1'b1, (k == sz - 1) && $urandom_range(1), 0, unused);
        done++;
      end
      // close the set unless the last sample already did
      if (loading_set) begin
        send_item($urandom, 1'b0, 1'b1, 0, unused);
        done++;
      end
      if ($urandom_range(15) == 0) begin
        send_item($urandom, 1'b0, 1'b1, 0, unused);
        done++;
      end
    end
  endtask

  // receiver stall pattern
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result check against oldest expectation
  always @(posedge clk) begin
    snapshot_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.cnt    = out_tdata[10:0];
      got.min_v  = out_tdata[42:11];
      got.max_v  = out_tdata[74:43];
      got.mean_v = out_tdata[122:75];
      for (int k = 0; k < 7; k++) got.qv[k] = out_tdata[123 + 48*k +: 48];
      got.ovf    = out_tuser[0];
      results_seen++;
      if (pending_snapshots.size() == 0) begin
        $display("%0t: unexpected result transaction, count=%0d", $time, got.cnt);
        errors++;
      end else begin
        want = pending_snapshots.pop_front();
        if (want.cnt != got.cnt || want.min_v != got.min_v || want.max_v != got.max_v ||
            want.mean_v != got.mean_v || want.ovf != got.ovf) begin
          $display("%0t: stats mismatch exp cnt=%0d min=%h max=%h mean=%h ovf=%b",
                   $time, want.cnt, want.min_v, want.max_v, want.mean_v, want.ovf);
          $display("%0t:                got cnt=%0d min=%h max=%h mean=%h ovf=%b",
                   $time, got.cnt, got.min_v, got.max_v, got.mean_v, got.ovf);
          errors++;
        end
        for (int k = 0; k < 7; k++)
          if (want.qv[k] != got.qv[k]) begin
            $display("%0t: quantile %0d mismatch exp=%h got=%h",
                     $time, k, want.qv[k], got.qv[k]);
            errors++;
          end
      end
    end
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_snapshots.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    snapshot_t typed_snap;
    int idle_tab[4], stall_tab[4];
    logic [31:0] level_tab[4];
    idle_tab  = '{0, 50, 0, 32};
    stall_tab = '{0, 0, 50, 32};
    level_tab = '{32'd0, 32'd1048576, 32'h001F_FFFF, 32'd0};
    level_tab[3] = $urandom_range(1048576);
    sorted_store.delete();
    loading_set = 1'b0;
    dropped = 1'b0;
    custom_level = 21'd524288;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at the reset level
    foreach (dir_rows[r]) begin
      typed_snap = '0;
      typed_snap.cnt = dir_rows[r].cnt;
      typed_snap.min_v = dir_rows[r].min_v;
      typed_snap.max_v = dir_rows[r].max_v;
      typed_snap.mean_v = dir_rows[r].mean_v;
      for (int k = 0; k < 7; k++) typed_snap.qv[k] = dir_rows[r].q_all;
      send_item(dir_rows[r].smp, dir_rows[r].has, dir_rows[r].lst,
                dir_rows[r].typed, typed_snap);
    end
    wait_drained();

    // random phases, each with its own level and idling mix
    typed_snap = '0;
    for (int ph = 0; ph < 4; ph++) begin
      write_level(level_tab[ph]);
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      random_sets(RAND_ITEMS);
      wait_drained();
    end

    // capacity: one full store plus dropped samples, then an empty last on it
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_level($urandom_range(1048576));
    for (int k = 0; k < MAX_SAMPLES + 6; k++)
      send_item($urandom, 1'b1, k == MAX_SAMPLES + 5, 0, typed_snap);
    send_item(32'h0, 1'b0, 1'b1, 0, typed_snap);
    send_item($urandom, 1'b1, 1'b1, 0, typed_snap);

    drop_valid();
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d input transactions over four idling phases and six levels;",
             items_sent);
    $display("checked %0d snapshots including a store filled past capacity.", results_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sqs_pkg.sv
rtl/sqs_ram.sv
rtl/sample_quantile_snapshot_core.sv
bench/sample_quantile_snapshot_core_tb.sv
